// ===== hw/rtl/longest_bounded_range_window_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the longest bounded-range window block.
// ---------------------------------------------------------------------------
`ifndef LONGEST_BOUNDED_RANGE_WINDOW_MACROS_SVH
`define LONGEST_BOUNDED_RANGE_WINDOW_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LBRW_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LBRW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LBRW_ASSERT(lbl, clk, rst_n, prop, msg)
`define LBRW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/lbrw_pkg.sv =====
// ---------------------------------------------------------------------------
// lbrw_pkg
// Shared types and constants of the longest bounded-range window block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package lbrw_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEN_W    = 11;
    localparam int RANGE_W  = 16;
    localparam int OUT_POS_W = 20;
    localparam int PADDR_W  = 4;

    localparam logic [1:0] REG_MIN_LENGTH  = 2'd0;
    localparam logic [1:0] REG_MAX_LENGTH  = 2'd1;
    localparam logic [1:0] REG_RANGE_LIMIT = 2'd2;

    localparam logic [LEN_W-1:0]   RST_MIN_LENGTH  = 11'd1;
    localparam logic [LEN_W-1:0]   RST_MAX_LENGTH  = 11'd1024;
    localparam logic [RANGE_W-1:0] RST_RANGE_LIMIT = 16'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FULL_RD,
        S_FULL_DROP,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_CHK_RD,
        S_CHK,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/longest_bounded_range_window.sv =====
// ---------------------------------------------------------------------------
// longest_bounded_range_window
// Tracks the longest recent window of samples whose max minus min is bounded.
// ---------------------------------------------------------------------------
// Samples arrive on the slave stream (s_tdata, signed 16 bits). Each accepted
// request gives exactly one result on the master stream: the found flag and
// the best window's length, 1-based start and 1-based end positions.
// The three registers (min_length, max_length, range_limit) sit on the APB
// port at byte addresses 0, 4 and 8; write them only while the block is idle.
// One sequencer drives a single shared compare unit and two queue memories.
// After the accept, a sample passes the optional drop when the store is full
// (read, then drop), a back read and compare per queue, repeated for each
// entry popped from a queue back, a window check (read, then check),
// repeated for each check that shrinks the window, and the post of the
// result. A new request is taken only after the last result is posted.
// Pops are amortized.
// The slave side is ready only while the sequencer is idle. A waiting result
// holds the next sample at its final step until the receiver accepts.
// Reset empties the queues and the best window and restores register defaults.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "longest_bounded_range_window_macros.svh"
module longest_bounded_range_window #(
    parameter int MAX_WINDOW    = 1024,
    parameter int POSITION_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [0] found, [11:1] best_length,
                                   // [31:12] best_start, [51:32] best_end
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [lbrw_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lbrw_pkg::*;

    localparam int SW = $clog2(MAX_WINDOW);       // slot and queue index bits
    localparam int CW = $clog2(MAX_WINDOW + 1);   // counts up to MAX_WINDOW
    localparam int PW = POSITION_BITS;

    // A queue entry carries the store slot and the sample it names, so the
    // back and front compares never need a separate store read.
    typedef struct packed {
        logic [SW-1:0]              slot;
        logic signed [SAMPLE_W-1:0] value;
    } t_entry;

    t_state r_state, n_state;

    logic [LEN_W-1:0]   r_min_length;
    logic [LEN_W-1:0]   r_max_length;
    logic [RANGE_W-1:0] r_range_limit;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_qsel;      // 0: max queue, 1: min queue
    logic [SW-1:0]              r_front [2];
    logic [CW-1:0]              r_cnt   [2];
    logic [CW-1:0]              r_win_len;
    logic [SW-1:0]              r_wslot;
    logic [PW-1:0]              r_head;
    logic [PW-1:0]              r_tail;
    logic [LEN_W-1:0]           r_best_len;
    logic [PW-1:0]              r_best_start;
    logic [PW-1:0]              r_best_end;
    logic                       r_out_valid;
    logic [55:0]                r_out_data;

    t_entry mem_max [MAX_WINDOW];
    t_entry mem_min [MAX_WINDOW];
    t_entry r_rd_max, r_rd_min;

    // Control decoded from the state.
    logic c_accept, c_drop, c_pop, c_push, c_post, c_rd_back;

    // ---------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length  <= RST_MIN_LENGTH;
            r_max_length  <= RST_MAX_LENGTH;
            r_range_limit <= RST_RANGE_LIMIT;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_MIN_LENGTH:  r_min_length  <= pwdata[LEN_W-1:0];
                REG_MAX_LENGTH:  r_max_length  <= pwdata[LEN_W-1:0];
                REG_RANGE_LIMIT: r_range_limit <= pwdata[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MIN_LENGTH:  prdata = 32'(r_min_length);
            REG_MAX_LENGTH:  prdata = 32'(r_max_length);
            REG_RANGE_LIMIT: prdata = 32'(r_range_limit);
            default:         prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // Queue addressing
    // ---------------------------------------------------------------
    // The back slot of each queue is front + count - 1, the free slot is
    // front + count, both taken modulo the queue depth.
    logic [SW-1:0] q_free [2];
    logic [SW-1:0] q_back [2];
    logic [SW-1:0] q_front_nx [2];
    logic [CW:0]   q_sum [2];

    always_comb begin
        for (int q = 0; q < 2; q++) begin
            q_sum[q]  = (CW+1)'(r_front[q]) + (CW+1)'(r_cnt[q]);
            if (q_sum[q] >= (CW+1)'(MAX_WINDOW)) begin
                q_free[q] = SW'(q_sum[q] - (CW+1)'(MAX_WINDOW));
            end else begin
                q_free[q] = SW'(q_sum[q]);
            end
            if (q_free[q] == '0) begin
                q_back[q] = SW'(MAX_WINDOW - 1);
            end else begin
                q_back[q] = q_free[q] - SW'(1);
            end
            if (r_front[q] == SW'(MAX_WINDOW - 1)) begin
                q_front_nx[q] = '0;
            end else begin
                q_front_nx[q] = r_front[q] + SW'(1);
            end
        end
    end

    // Slot of the oldest sample still in the window.
    logic [SW-1:0] oldest_slot;
    always_comb begin
        if ((CW+1)'(r_wslot) >= (CW+1)'(r_win_len)) begin
            oldest_slot = SW'((CW+1)'(r_wslot) - (CW+1)'(r_win_len));
        end else begin
            oldest_slot = SW'((CW+1)'(r_wslot) + (CW+1)'(MAX_WINDOW)
                              - (CW+1)'(r_win_len));
        end
    end

    // ---------------------------------------------------------------
    // Shared compare unit: back entry of the selected queue against the
    // new sample. The operands swap so one signed <= serves both queues.
    // ---------------------------------------------------------------
    logic signed [SAMPLE_W-1:0] cmp_a, cmp_b, back_val;
    logic                        back_pop;
    always_comb begin
        back_val = r_qsel ? r_rd_min.value : r_rd_max.value;
        cmp_a    = r_qsel ? r_sample : back_val;
        cmp_b    = r_qsel ? back_val : r_sample;
        back_pop = (r_cnt[r_qsel] != '0) && (cmp_a <= cmp_b);
    end

    // Window range and shrink decision.
    logic signed [SAMPLE_W:0] win_range;
    logic [31:0]              eff_max;
    logic [LEN_W-1:0]         eff_min;
    logic                     shrink;
    logic                     qualifies;
    always_comb begin
        win_range = {r_rd_max.value[SAMPLE_W-1], r_rd_max.value}
                  - {r_rd_min.value[SAMPLE_W-1], r_rd_min.value};
        eff_max   = (32'(r_max_length) > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW)
                                                          : 32'(r_max_length);
        eff_min   = (r_min_length == '0) ? LEN_W'(1) : r_min_length;
        shrink    = (r_win_len != '0) &&
                    (($unsigned(win_range) > (SAMPLE_W+1)'(r_range_limit)) ||
                     (32'(r_win_len) > eff_max));
        qualifies = (r_win_len != '0) &&
                    (32'(r_win_len) >= 32'(eff_min)) &&
                    (32'(r_win_len) <= 32'(r_max_length)) &&
                    (32'(r_win_len) >= 32'(r_best_len));
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_state = (32'(r_win_len) >= 32'(MAX_WINDOW)) ? S_FULL_RD
                                                                  : S_PUSH_RD;
                end
            end
            S_FULL_RD:   n_state = S_FULL_DROP;
            S_FULL_DROP: n_state = S_PUSH_RD;
            S_PUSH_RD:   n_state = S_PUSH_CMP;
            S_PUSH_CMP: begin
                if (back_pop || !r_qsel) begin
                    n_state = S_PUSH_RD;
                end else begin
                    n_state = S_CHK_RD;
                end
            end
            S_CHK_RD: n_state = S_CHK;
            S_CHK:    n_state = shrink ? S_CHK_RD : S_DONE;
            S_DONE: begin
                if (!r_out_valid || m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        c_accept  = 1'b0;
        c_drop    = 1'b0;
        c_pop     = 1'b0;
        c_push    = 1'b0;
        c_post    = 1'b0;
        c_rd_back = 1'b0;
        case (r_state)
            S_IDLE:      c_accept  = s_tvalid;
            S_FULL_DROP: c_drop    = 1'b1;
            S_PUSH_RD:   c_rd_back = 1'b1;
            S_PUSH_CMP: begin
                c_pop  = back_pop;
                c_push = !back_pop;
            end
            S_CHK:       c_drop = shrink;
            S_DONE:      c_post = !r_out_valid || m_tready;
            default: ;
        endcase
    end

    assign s_tready = (r_state == S_IDLE);

    // ---------------------------------------------------------------
    // Queue memories: one write and one registered read each per cycle.
    // ---------------------------------------------------------------
    t_entry new_entry;
    assign new_entry = '{slot: r_wslot, value: r_sample};

    always_ff @(posedge i_clk) begin
        if (c_push && !r_qsel) begin
            mem_max[q_free[0]] <= new_entry;
        end
        r_rd_max <= mem_max[c_rd_back ? q_back[0] : r_front[0]];
    end

    always_ff @(posedge i_clk) begin
        if (c_push && r_qsel) begin
            mem_min[q_free[1]] <= new_entry;
        end
        r_rd_min <= mem_min[c_rd_back ? q_back[1] : r_front[1]];
    end

    // ---------------------------------------------------------------
    // Window state
    // ---------------------------------------------------------------
    logic drop_q [2];
    always_comb begin
        drop_q[0] = (r_cnt[0] != '0) && (r_rd_max.slot == oldest_slot);
        drop_q[1] = (r_cnt[1] != '0) && (r_rd_min.slot == oldest_slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qsel     <= 1'b0;
            r_front    <= '{default: '0};
            r_cnt      <= '{default: '0};
            r_win_len  <= '0;
            r_wslot    <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_best_len <= '0;
            r_best_start <= '0;
            r_best_end   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (c_accept) begin
                r_sample <= signed'(s_tdata);
                r_qsel   <= 1'b0;
            end
            if (c_drop) begin
                for (int q = 0; q < 2; q++) begin
                    if (drop_q[q]) begin
                        r_front[q] <= q_front_nx[q];
                        r_cnt[q]   <= r_cnt[q] - CW'(1);
                    end
                end
                r_win_len <= r_win_len - CW'(1);
                r_tail    <= r_tail + PW'(1);
            end
            if (c_pop) begin
                r_cnt[r_qsel] <= r_cnt[r_qsel] - CW'(1);
            end
            if (c_push) begin
                r_cnt[r_qsel] <= r_cnt[r_qsel] + CW'(1);
                r_qsel        <= 1'b1;
                if (r_qsel) begin
                    r_wslot   <= (r_wslot == SW'(MAX_WINDOW - 1)) ? '0
                                                                  : r_wslot + SW'(1);
                    r_win_len <= r_win_len + CW'(1);
                    r_head    <= r_head + PW'(1);
                end
            end
            // A new result may be posted in the same cycle the old one leaves.
            if (c_post) begin
                r_out_valid <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (c_post) begin
                if (qualifies) begin
                    r_best_len   <= LEN_W'(r_win_len);
                    r_best_start <= r_tail + PW'(1);
                    r_best_end   <= r_head;
                    r_out_data   <= {4'd0, OUT_POS_W'(r_head),
                                     OUT_POS_W'(r_tail + PW'(1)),
                                     LEN_W'(r_win_len), 1'b1};
                end else begin
                    r_out_data   <= {4'd0, OUT_POS_W'(r_best_end),
                                     OUT_POS_W'(r_best_start),
                                     r_best_len, (r_best_len != '0)};
                end
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `LBRW_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n,
        (s_tvalid && s_tready) |=> (r_state != S_IDLE),
        "sequencer stayed idle after taking a sample")
    `LBRW_ASSERT(a_win_len_bound, i_clk, i_rst_n,
        32'(r_win_len) <= 32'(MAX_WINDOW),
        "window longer than the store")
    `LBRW_ASSERT(a_queue_bound, i_clk, i_rst_n,
        (32'(r_cnt[0]) <= 32'(r_win_len) + 32'd1) &&
        (32'(r_cnt[1]) <= 32'(r_win_len) + 32'd1),
        "queue holds more entries than the window")
    `LBRW_ASSERT(a_best_monotone, i_clk, i_rst_n,
        1'b1 |=> (r_best_len >= $past(r_best_len)),
        "best length decreased")

endmodule
